### rtl/core/shifted_bitmap_row_blit_top_defines.svh
// assertion macros used by the bitmap blitter rtl
`ifndef SHIFTED_BITMAP_ROW_BLIT_TOP_DEFINES_SVH
`define SHIFTED_BITMAP_ROW_BLIT_TOP_DEFINES_SVH

// same-cycle implication, checked on clk_i, off during reset
`define SBRB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, checked on clk_i, off during reset
`define SBRB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### rtl/core/sbrb_pkg.sv
// types, state codes and the pixel merge function of the bitmap blitter
package sbrb_pkg;

  localparam int unsigned WordBits = 32;
  localparam logic [WordBits-1:0] AllOnes = 32'hFFFF_FFFF;

  // item function codes
  localparam logic FuncBlit = 1'b0;
  localparam logic FuncRead = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE
  } state_e;

  // one write lane into a framebuffer bank
  typedef struct packed {
    logic                en;
    logic [WordBits-1:0] data;
    logic [WordBits-1:0] span;
  } lane_t;

  // combine shifted pattern bits with the old framebuffer word
  function automatic logic [WordBits-1:0] sbrb_merge(
    input logic [WordBits-1:0] old_word,
    input logic [WordBits-1:0] data,
    input logic [WordBits-1:0] span,
    input logic                replace,
    input logic                black
  );
    logic [WordBits-1:0] res;
    if (replace) begin
      res = (old_word & ~span) | (black ? (data ^ span) : data);
    end else if (black) begin
      res = old_word ^ data;
    end else begin
      res = old_word | data;
    end
    return res;
  endfunction

endpackage

### rtl/core/shifted_bitmap_row_blit_top.sv
// Monochrome bitmap row blitter over a banked 1-bit-per-pixel framebuffer.
// Command channel: an item is taken at a rising edge with start high and busy
// low. func_i selects a blit of one 32-pixel row at pos_x_i/row_y_i in the
// mode given by replace_mode_i/black_mode_i, or a read of one framebuffer
// word at read_addr_i.
// Result channel: every item gives one result, shown for exactly one cycle
// with result_valid_o high; the receiver cannot stall it.
// The result strobe is registered: it follows the read state and the
// write-back state of the item, then the output register.
// Words are split over an even and an odd single-port bank, so both words
// touched by a row are read in the same cycle and written back in the next;
// a new item is taken during the write-back, before the result of the last
// one is out. Reset: the framebuffer is cleared by a pass over the banks,
// one entry of each bank per cycle; busy stays high during that pass.
`include "shifted_bitmap_row_blit_top_defines.svh"

module shifted_bitmap_row_blit_top import sbrb_pkg::*; #(
  parameter int unsigned ROW_WORDS   = 20,
  parameter int unsigned SCREEN_ROWS = 400
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                func_i,
  input  logic signed [10:0]  pos_x_i,
  input  logic signed [10:0]  row_y_i,
  input  logic [31:0]         pattern_i,
  input  logic                replace_mode_i,
  input  logic                black_mode_i,
  input  logic                last_row_i,
  input  logic [12:0]         read_addr_i,
  output logic                result_valid_o,
  output logic [31:0]         read_data_o,
  output logic                drawn_o,
  output logic                sprite_done_o
);

  localparam int unsigned Depth     = ROW_WORDS * SCREEN_ROWS;
  localparam int unsigned AddrW     = $clog2(Depth);
  localparam int unsigned BankDepth = (Depth + 1) / 2;
  localparam int unsigned BankAddrW = (BankDepth > 1) ? $clog2(BankDepth) : 1;

  state_e state_q, state_d;
  logic   accept;

  // latched item
  logic               func_q;
  logic signed [10:0] pos_x_q, row_y_q;
  logic [31:0]        pattern_q;
  logic               replace_q, black_q, last_q;
  logic [12:0]        read_addr_q;

  logic [BankAddrW-1:0] clr_q, clr_d;

  logic                 draw_ok;
  logic [BankAddrW-1:0] even_addr, odd_addr, rd_baddr;
  lane_t                even_lane, odd_lane;
  logic                 rd_in_range;

  logic [BankAddrW-1:0] even_maddr, odd_maddr;
  logic                 even_we, odd_we;
  logic [31:0]          even_wdata, odd_wdata, even_rdata, odd_rdata;

  logic        result_valid_q, result_valid_d;
  logic [31:0] read_data_q, read_data_d;
  logic        drawn_q, drawn_d, sprite_done_q, sprite_done_d;

  assign accept = start && !busy;

  // state register, clear counter and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_q          <= '0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      clr_q          <= clr_d;
      result_valid_q <= result_valid_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + BankAddrW'(1);
        if (clr_q == BankAddrW'(BankDepth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        state_d = start ? ST_READ : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // handshake output
  always_comb begin
    case (state_q)
      ST_CLEAR: busy = 1'b1;
      ST_READ:  busy = 1'b1;
      default:  busy = 1'b0;
    endcase
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q      <= func_i;
      pos_x_q     <= pos_x_i;
      row_y_q     <= row_y_i;
      pattern_q   <= pattern_i;
      replace_q   <= replace_mode_i;
      black_q     <= black_mode_i;
      last_q      <= last_row_i;
      read_addr_q <= read_addr_i;
    end
  end

  sbrb_place #(
    .RowWords   (ROW_WORDS),
    .ScreenRows (SCREEN_ROWS),
    .AddrW      (AddrW),
    .BankAddrW  (BankAddrW)
  ) u_place (
    .pos_x_i     (pos_x_q),
    .row_y_i     (row_y_q),
    .pattern_i   (pattern_q),
    .draw_ok_o   (draw_ok),
    .even_addr_o (even_addr),
    .odd_addr_o  (odd_addr),
    .even_lane_o (even_lane),
    .odd_lane_o  (odd_lane)
  );

  // read address into the banks
  assign rd_baddr    = BankAddrW'(read_addr_q >> 1);
  assign rd_in_range = (32'(read_addr_q) < Depth);

  // bank access: clear pass, read, then merge and write back
  always_comb begin
    even_maddr = '0;
    odd_maddr  = '0;
    even_we    = 1'b0;
    odd_we     = 1'b0;
    even_wdata = '0;
    odd_wdata  = '0;
    case (state_q)
      ST_CLEAR: begin
        even_maddr = clr_q;
        odd_maddr  = clr_q;
        even_we    = 1'b1;
        odd_we     = 1'b1;
      end
      ST_READ, ST_WRITE: begin
        if (func_q == FuncRead) begin
          even_maddr = rd_baddr;
          odd_maddr  = rd_baddr;
        end else begin
          even_maddr = even_addr;
          odd_maddr  = odd_addr;
          even_we    = (state_q == ST_WRITE) && even_lane.en;
          odd_we     = (state_q == ST_WRITE) && odd_lane.en;
          even_wdata = sbrb_merge(even_rdata, even_lane.data, even_lane.span,
                                  replace_q, black_q);
          odd_wdata  = sbrb_merge(odd_rdata, odd_lane.data, odd_lane.span,
                                  replace_q, black_q);
        end
      end
      default: begin
        even_we = 1'b0;
        odd_we  = 1'b0;
      end
    endcase
  end

  sbrb_mem #(
    .Depth (BankDepth),
    .AddrW (BankAddrW)
  ) u_mem_even (
    .clk_i   (clk_i),
    .addr_i  (even_maddr),
    .we_i    (even_we),
    .wdata_i (even_wdata),
    .rdata_o (even_rdata)
  );

  sbrb_mem #(
    .Depth (BankDepth),
    .AddrW (BankAddrW)
  ) u_mem_odd (
    .clk_i   (clk_i),
    .addr_i  (odd_maddr),
    .we_i    (odd_we),
    .wdata_i (odd_wdata),
    .rdata_o (odd_rdata)
  );

  // result formed during write-back
  always_comb begin
    result_valid_d = (state_q == ST_WRITE);
    read_data_d    = '0;
    drawn_d        = 1'b0;
    sprite_done_d  = 1'b0;
    if (func_q == FuncRead) begin
      if (rd_in_range) begin
        read_data_d = read_addr_q[0] ? odd_rdata : even_rdata;
      end
    end else begin
      drawn_d       = draw_ok;
      sprite_done_d = last_q;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (state_q == ST_WRITE) begin
      read_data_q   <= read_data_d;
      drawn_q       <= drawn_d;
      sprite_done_q <= sprite_done_d;
    end
  end

  assign result_valid_o = result_valid_q;
  assign read_data_o    = read_data_q;
  assign drawn_o        = drawn_q;
  assign sprite_done_o  = sprite_done_q;

  // checks
  `SBRB_ASSERT_NXT(a_read_then_write, state_q == ST_READ, state_q == ST_WRITE)
  `SBRB_ASSERT_IMP(a_no_write_idle, state_q == ST_IDLE || state_q == ST_READ, !even_we && !odd_we)
  `SBRB_ASSERT_IMP(a_strobe_after_write, result_valid_o, $past(state_q) == ST_WRITE)
  `SBRB_ASSERT_NXT(a_clear_exit, state_q == ST_CLEAR, state_q == ST_CLEAR || state_q == ST_IDLE)
  `SBRB_ASSERT_IMP(a_read_no_write, func_q == FuncRead && state_q == ST_WRITE, !even_we && !odd_we)

endmodule

### rtl/core/sbrb_mem.sv
// single-port framebuffer bank with registered read data
module sbrb_mem import sbrb_pkg::*; #(
  parameter int unsigned Depth = 4000,
  parameter int unsigned AddrW = 12
) (
  input  logic                clk_i,
  input  logic [AddrW-1:0]    addr_i,
  input  logic                we_i,
  input  logic [WordBits-1:0] wdata_i,
  output logic [WordBits-1:0] rdata_o
);

  logic [WordBits-1:0] mem_q [Depth];
  logic [WordBits-1:0] rdata_q;

  // write or read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/sbrb_place.sv
// clipping, word placement and bank steering of one bitmap row
module sbrb_place import sbrb_pkg::*; #(
  parameter int unsigned RowWords   = 20,
  parameter int unsigned ScreenRows = 400,
  parameter int unsigned AddrW      = 13,
  parameter int unsigned BankAddrW  = 12
) (
  input  logic signed [10:0]   pos_x_i,
  input  logic signed [10:0]   row_y_i,
  input  logic [WordBits-1:0]  pattern_i,
  output logic                 draw_ok_o,
  output logic [BankAddrW-1:0] even_addr_o,
  output logic [BankAddrW-1:0] odd_addr_o,
  output lane_t                even_lane_o,
  output lane_t                odd_lane_o
);

  localparam int ScreenCols = int'(RowWords) * 32;

  logic              x_ok, y_ok;
  logic [11:0]       xs;
  logic [4:0]        shift;
  logic [6:0]        wp1;
  logic [AddrW-1:0]  base;
  logic [AddrW:0]    idx_r, idx_l;
  logic              l_en, r_en;
  logic [2*WordBits-1:0] data64, span64;
  lane_t             lane_l, lane_r;
  logic [BankAddrW-1:0] addr_l, addr_r;

  // clipping of whole rows
  assign x_ok = (int'(pos_x_i) >= -31) && (int'(pos_x_i) < ScreenCols);
  assign y_ok = !row_y_i[10] && (int'(row_y_i) < int'(ScreenRows));
  assign draw_ok_o = x_ok && y_ok;

  // word position and bit offset, biased so the left word index is wp1 - 1
  assign xs    = 12'($signed({pos_x_i[10], pos_x_i}) + 12'sd32);
  assign shift = xs[4:0];
  assign wp1   = xs[11:5];

  // framebuffer word indexes of the right and left parts
  assign base  = AddrW'(32'(row_y_i[9:0]) * RowWords);
  assign idx_r = (AddrW+1)'(base) + (AddrW+1)'(wp1);
  assign idx_l = idx_r - (AddrW+1)'(1);
  assign addr_l = BankAddrW'(idx_l >> 1);
  assign addr_r = BankAddrW'(idx_r >> 1);

  // parts that stay on screen
  assign l_en = draw_ok_o && (wp1 != 7'd0);
  assign r_en = draw_ok_o && (shift != 5'd0) && (int'(wp1) < int'(RowWords));

  // shifted pattern and the mask of the pixels under it
  assign data64 = {pattern_i, {WordBits{1'b0}}} >> shift;
  assign span64 = {AllOnes, {WordBits{1'b0}}} >> shift;

  assign lane_l = '{en: l_en, data: data64[2*WordBits-1:WordBits],
                    span: span64[2*WordBits-1:WordBits]};
  assign lane_r = '{en: r_en, data: data64[WordBits-1:0], span: span64[WordBits-1:0]};

  // neighboring words always fall into opposite banks
  always_comb begin
    if (idx_l[0]) begin
      even_addr_o = addr_r;
      even_lane_o = lane_r;
      odd_addr_o  = addr_l;
      odd_lane_o  = lane_l;
    end else begin
      even_addr_o = addr_l;
      even_lane_o = lane_l;
      odd_addr_o  = addr_r;
      odd_lane_o  = lane_r;
    end
  end

endmodule

### tb/tb.sv
// self-checking testbench for the monochrome bitmap row blitter
module tb;
  import sbrb_pkg::*;

  localparam int unsigned ROW_WORDS   = 20;
  localparam int unsigned SCREEN_ROWS = 400;
  localparam int          FRAME_WORDS = ROW_WORDS * SCREEN_ROWS;
  localparam int          CYCLE_LIMIT = 500000;
  localparam int          SHOW_LIMIT  = 10;

  typedef struct {
    logic               func;
    logic signed [10:0] pos_x;
    logic signed [10:0] row_y;
    logic [31:0]        pattern;
    logic               replace_mode;
    logic               black_mode;
    logic               last_row;
    logic [12:0]        read_addr;
  } blit_item_t;

  typedef struct {
    logic [31:0] read_data;
    logic        drawn;
    logic        sprite_done;
  } blit_result_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               start          = 1'b0;
  logic               busy;
  logic               func_i         = FuncBlit;
  logic signed [10:0] pos_x_i        = '0;
  logic signed [10:0] row_y_i        = '0;
  logic [31:0]        pattern_i      = '0;
  logic               replace_mode_i = 1'b0;
  logic               black_mode_i   = 1'b0;
  logic               last_row_i     = 1'b0;
  logic [12:0]        read_addr_i    = '0;
  logic               result_valid_o;
  logic [31:0]        read_data_o;
  logic               drawn_o;
  logic               sprite_done_o;

  // predicted framebuffer contents and results still to come
  logic [31:0]  frame_model [FRAME_WORDS];
  blit_result_t pending_results[$];
  int           fail_count  = 0;
  int           cycle_count = 0;
  bit           burst_mode  = 1'b0;

  shifted_bitmap_row_blit_top #(
    .ROW_WORDS  (ROW_WORDS),
    .SCREEN_ROWS(SCREEN_ROWS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .pos_x_i       (pos_x_i),
    .row_y_i       (row_y_i),
    .pattern_i     (pattern_i),
    .replace_mode_i(replace_mode_i),
    .black_mode_i  (black_mode_i),
    .last_row_i    (last_row_i),
    .read_addr_i   (read_addr_i),
    .result_valid_o(result_valid_o),
    .read_data_o   (read_data_o),
    .drawn_o       (drawn_o),
    .sprite_done_o (sprite_done_o)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // combine one word of shifted pixels with the old screen word
  function automatic logic [31:0] mix_pixels(input logic [31:0] old, input logic [31:0] bits,
                                             input logic [31:0] under, input logic rep,
                                             input logic inv);
    if (rep) return (old & ~under) | (inv ? (~bits & under) : bits);
    return inv ? (old ^ bits) : (old | bits);
  endfunction

  // expected result of one item, updates the framebuffer copy for blits
  function automatic blit_result_t predict_result(input blit_item_t it);
    blit_result_t res;
    int           x;
    int           y;
    int           w;
    int           s;
    int           base;
    logic [63:0]  bits;
    logic [63:0]  under;
    res = '{read_data: '0, drawn: 1'b0, sprite_done: 1'b0};
    if (it.func == FuncRead) begin
      if (int'(it.read_addr) < FRAME_WORDS) res.read_data = frame_model[it.read_addr];
      return res;
    end
    res.sprite_done = it.last_row;
    x = int'(it.pos_x);
    y = int'(it.row_y);
    if (x >= -31 && x < int'(ROW_WORDS) * 32 && y >= 0 && y < int'(SCREEN_ROWS)) begin
      w     = (x + 32) / 32 - 1;
      s     = (x + 32) % 32;
      bits  = {it.pattern, 32'h0} >> s;
      under = {AllOnes, 32'h0} >> s;
      base  = y * int'(ROW_WORDS);
      if (w >= 0) begin
        frame_model[base + w] = mix_pixels(frame_model[base + w], bits[63:32], under[63:32],
                                           it.replace_mode, it.black_mode);
      end
      if (s != 0 && w + 1 < int'(ROW_WORDS)) begin
        frame_model[base + w + 1] = mix_pixels(frame_model[base + w + 1], bits[31:0],
                                               under[31:0], it.replace_mode, it.black_mode);
      end
      res.drawn = 1'b1;
    end
    return res;
  endfunction

  // idle cycles before the next item: none in burst mode, otherwise mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic blit_item_t make_blit(input int x, input int y, input logic [31:0] pat,
                                           input logic rep, input logic inv, input logic last);
    blit_item_t it;
    it.func         = FuncBlit;
    it.pos_x        = x[10:0];
    it.row_y        = y[10:0];
    it.pattern      = pat;
    it.replace_mode = rep;
    it.black_mode   = inv;
    it.last_row     = last;
    it.read_addr    = 13'($urandom);
    return it;
  endfunction

  // reads carry random junk in the fields the block ignores
  function automatic blit_item_t make_read(input int addr);
    blit_item_t it;
    it           = make_blit($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    it.func      = FuncRead;
    it.read_addr = addr[12:0];
    return it;
  endfunction

  function automatic logic [31:0] rand_pattern();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 32'h0;
    if (r == 1) return AllOnes;
    return $urandom;
  endfunction

  // present one item and hold it until the block takes it
  task automatic send_item(input blit_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start          <= 1'b1;
    func_i         <= it.func;
    pos_x_i        <= it.pos_x;
    row_y_i        <= it.row_y;
    pattern_i      <= it.pattern;
    replace_mode_i <= it.replace_mode;
    black_mode_i   <= it.black_mode;
    last_row_i     <= it.last_row;
    read_addr_i    <= it.read_addr;
    do @(posedge clk_i); while (busy !== 1'b0);
    pending_results.push_back(predict_result(it));
  endtask

  // screen edges, clipping, every mode, out of range reads
  task automatic test_edges();
    send_item(make_read(0));
    send_item(make_blit(0, 0, AllOnes, 1'b0, 1'b0, 1'b0));
    send_item(make_read(0));
    send_item(make_blit(-1, 1, 32'hA5A5_A5A5, 1'b0, 1'b0, 1'b0));
    send_item(make_blit(-31, 1, AllOnes, 1'b1, 1'b1, 1'b1));
    send_item(make_read(ROW_WORDS));
    send_item(make_blit(639, 399, AllOnes, 1'b0, 1'b0, 1'b0));
    send_item(make_blit(608, 399, 32'h1234_5678, 1'b0, 1'b1, 1'b1));
    send_item(make_read(FRAME_WORDS - 1));
    // rows clipped away entirely
    send_item(make_blit(640, 5, AllOnes, 1'b0, 1'b0, 1'b0));
    send_item(make_blit(-32, 5, AllOnes, 1'b0, 1'b0, 1'b1));
    send_item(make_blit(1023, -1, AllOnes, 1'b1, 1'b0, 1'b0));
    send_item(make_blit(-1024, 1023, AllOnes, 1'b1, 1'b1, 1'b1));
    send_item(make_blit(17, 400, AllOnes, 1'b0, 1'b1, 1'b0));
    send_item(make_read(5 * ROW_WORDS));
    // replace modes keep pixels outside the span
    send_item(make_blit(0, 2, AllOnes, 1'b0, 1'b0, 1'b0));
    send_item(make_blit(32, 2, AllOnes, 1'b0, 1'b0, 1'b0));
    send_item(make_blit(17, 2, 32'hF0F0_F0F0, 1'b1, 1'b0, 1'b0));
    send_item(make_read(2 * ROW_WORDS));
    send_item(make_read(2 * ROW_WORDS + 1));
    send_item(make_blit(-5, 2, 32'h0F0F_0F0F, 1'b1, 1'b1, 1'b1));
    send_item(make_read(2 * ROW_WORDS));
    send_item(make_read(FRAME_WORDS));
    send_item(make_read(8191));
    send_item(make_read(4096));
  endtask

  // well-formed sprites, each followed by a readback of the words it covered
  task automatic test_sprites(input int n_sprites);
    int   x;
    int   y0;
    int   y;
    int   h;
    int   kind;
    int   left;
    logic rep;
    logic inv;
    for (int k = 0; k < n_sprites; k++) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        x  = int'($urandom_range(0, 160)) - 40;
        y0 = $urandom_range(0, 10);
      end else if (kind < 8) begin
        x  = int'($urandom_range(0, 670)) - 31;
        y0 = $urandom_range(0, 399);
      end else begin
        x  = $urandom_range(0, 1) ? int'($urandom_range(0, 4)) - 33
                                  : int'($urandom_range(606, 641));
        y0 = $urandom_range(0, 1) ? int'($urandom_range(0, 15)) - 10
                                  : int'($urandom_range(390, 405));
      end
      h   = $urandom_range(1, 12);
      rep = 1'($urandom_range(0, 1));
      inv = 1'($urandom_range(0, 1));
      for (int r = 0; r < h; r++) begin
        send_item(make_blit(x, y0 + r, rand_pattern(), rep, inv, r == h - 1));
      end
      // read back the covered words, or a random word of a row clipped only in x
      for (int r = 0; r < h; r++) begin
        y = y0 + r;
        if (y >= 0 && y < int'(SCREEN_ROWS)) begin
          if (x >= -31 && x < int'(ROW_WORDS) * 32) begin
            left = (x + 32) / 32 - 1;
            for (int c = left; c <= left + 1; c++) begin
              if (c >= 0 && c < int'(ROW_WORDS)) send_item(make_read(y * ROW_WORDS + c));
            end
          end else begin
            send_item(make_read(y * ROW_WORDS + $urandom_range(0, ROW_WORDS - 1)));
          end
        end
      end
    end
    burst_mode = 1'b0;
  endtask

  // unstructured items, partly near the top left corner, partly over the whole field ranges
  task automatic test_noise(input int n_items);
    blit_item_t it;
    for (int k = 0; k < n_items; k++) begin
      if (k % 50 == 0) burst_mode = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 1)) begin
        it = make_read($urandom_range(0, 1) ? $urandom_range(0, 300) : $urandom_range(0, 8191));
      end else if ($urandom_range(0, 1)) begin
        it = make_blit(int'($urandom_range(0, 140)) - 35, $urandom_range(0, 12), $urandom,
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
      end else begin
        it = make_blit($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      send_item(it);
    end
    burst_mode = 1'b0;
  endtask

  // compare each result with the oldest prediction
  always @(posedge clk_i) begin
    blit_result_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOW_LIMIT) begin
          $display("unexpected result: read_data %h drawn %b sprite_done %b",
                   read_data_o, drawn_o, sprite_done_o);
        end
      end else begin
        want = pending_results.pop_front();
        if (read_data_o !== want.read_data || drawn_o !== want.drawn ||
            sprite_done_o !== want.sprite_done) begin
          fail_count++;
          if (fail_count <= SHOW_LIMIT) begin
            $display("mismatch: read_data %h/%h drawn %b/%b sprite_done %b/%b (exp/got)",
                     want.read_data, read_data_o, want.drawn, drawn_o,
                     want.sprite_done, sprite_done_o);
          end
        end
      end
    end
  end

  // test sequence
  initial begin
    for (int i = 0; i < FRAME_WORDS; i++) frame_model[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_edges();
    test_sprites(60);
    test_noise(400);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### shifted_bitmap_row_blit_top.f
+incdir+rtl/core
rtl/core/sbrb_pkg.sv
rtl/core/sbrb_mem.sv
rtl/core/sbrb_place.sv
rtl/core/shifted_bitmap_row_blit_top.sv
tb/tb.sv
